### src/pwlc_pkg.sv
// package for the pulse width link classifier
// holds opcodes, register indexes, reset values and the result word type
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pwlc_pkg;

  localparam int unsigned OpW      = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned WidthW   = 16;
  localparam int unsigned LinkCntW = 12;
  localparam int unsigned StepW    = 8;
  localparam int unsigned GapW     = 11;

  localparam int unsigned OvfLimitDefault = 63;

  localparam logic [StepW-1:0]  TickStepRst    = StepW'(10);
  localparam logic [GapW-1:0]   LostLimitRst   = GapW'(1000);
  localparam logic [GapW-1:0]   GapLowRst      = GapW'(100);
  localparam logic [GapW-1:0]   GapHighRst     = GapW'(500);
  localparam logic [WidthW-1:0] PressLowRst    = WidthW'(150);
  localparam logic [WidthW-1:0] BandSplitRst   = WidthW'(250);
  localparam logic [WidthW-1:0] ReleaseHighRst = WidthW'(350);

  localparam logic [WidthW-1:0] WidthSat = '1;

  typedef enum logic [OpW-1:0] {
    OP_CAPTURE = 2'd0,
    OP_TICK    = 2'd1,
    OP_ACK     = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TICK_STEP    = 3'd0,
    CFG_LOST_LIMIT   = 3'd1,
    CFG_GAP_LOW      = 3'd2,
    CFG_GAP_HIGH     = 3'd3,
    CFG_PRESS_LOW    = 3'd4,
    CFG_BAND_SPLIT   = 3'd5,
    CFG_RELEASE_HIGH = 3'd6
  } cfg_e;

  typedef struct packed {
    logic              falling_select;
    logic              restart_timer;
    logic              capture_ended;
    logic [WidthW-1:0] pulse_width;
    logic              link_present;
    logic              gap_flag;
    logic              key_pressed;
    logic              press_mark;
  } res_t;

endpackage

`default_nettype wire

### src/pulse_width_link_classifier.sv
// pulse width link classifier: input capture pulse measurement and link supervision
// each accepted word's result is registered in the output or the skid register
// throughput: one word per cycle; the state update is a single pass of compares and adds
// a two-entry output (result register plus skid register) keeps input open while a
// result waits; input stalls only when both entries hold words
// reset clears all state, sets registers to their defaults and empties the output
`timescale 1ns / 1ps
`default_nettype none

module pulse_width_link_classifier
  import pwlc_pkg::*;
#(
  parameter int unsigned OVERFLOW_LIMIT = OvfLimitDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,

  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [OpW-1:0]      opcode_i,
  input  wire logic                overflow_event_i,
  input  wire logic                edge_event_i,
  input  wire logic [WidthW-1:0]   edge_count_i,
  input  wire logic                line_level_i,

  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     falling_select_o,
  output logic                     restart_timer_o,
  output logic                     capture_ended_o,
  output logic [WidthW-1:0]        pulse_width_o,
  output logic                     link_present_o,
  output logic                     gap_flag_o,
  output logic                     key_pressed_o,
  output logic                     press_mark_o
);

  localparam int unsigned OvfW = $clog2(OVERFLOW_LIMIT + 1);
  localparam logic [OvfW-1:0] OvfMax = OvfW'(OVERFLOW_LIMIT);

  // configuration registers
  logic [StepW-1:0]  tick_step_q;
  logic [GapW-1:0]   lost_limit_q, gap_low_q, gap_high_q;
  logic [WidthW-1:0] press_low_q, band_split_q, release_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_step_q    <= TickStepRst;
      lost_limit_q   <= LostLimitRst;
      gap_low_q      <= GapLowRst;
      gap_high_q     <= GapHighRst;
      press_low_q    <= PressLowRst;
      band_split_q   <= BandSplitRst;
      release_high_q <= ReleaseHighRst;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_TICK_STEP:    tick_step_q    <= cfg_data_i[StepW-1:0];
        CFG_LOST_LIMIT:   lost_limit_q   <= cfg_data_i[GapW-1:0];
        CFG_GAP_LOW:      gap_low_q      <= cfg_data_i[GapW-1:0];
        CFG_GAP_HIGH:     gap_high_q     <= cfg_data_i[GapW-1:0];
        CFG_PRESS_LOW:    press_low_q    <= cfg_data_i;
        CFG_BAND_SPLIT:   band_split_q   <= cfg_data_i;
        CFG_RELEASE_HIGH: release_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake
  logic out_valid_q, skid_valid_q;
  logic in_acc, out_take;
  res_t out_q, skid_q, res_d;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;

  // block state
  logic                ended_q, ended_d;
  logic                armed_q, armed_d;
  logic [OvfW-1:0]     ovf_cnt_q, ovf_cnt_d;
  logic [WidthW-1:0]   width_q, width_d;
  logic                falling_q, falling_d;
  logic [LinkCntW-1:0] sup_cnt_q, sup_cnt_d;
  logic                link_q, link_d;
  logic                gap_q, gap_d;
  logic                key_q, key_d;
  logic                press_q, press_d;
  logic                restart;
  logic [LinkCntW-1:0] link_base;

  always_comb begin
    ended_d   = ended_q;
    armed_d   = armed_q;
    ovf_cnt_d = ovf_cnt_q;
    width_d   = width_q;
    falling_d = falling_q;
    sup_cnt_d = sup_cnt_q;
    link_d    = link_q;
    gap_d     = gap_q;
    key_d     = key_q;
    press_d   = press_q;
    restart   = 1'b0;
    link_base = sup_cnt_q;

    case (op_e'(opcode_i))
      OP_CAPTURE: begin
        if (!ended_q) begin
          if (overflow_event_i && armed_q) begin
            if (ovf_cnt_q >= OvfMax) begin
              ended_d = 1'b1;
              width_d = WidthSat;
            end else begin
              ovf_cnt_d = ovf_cnt_q + OvfW'(1);
            end
          end
          // edge is handled after the overflow, even if that just ended the capture
          if (edge_event_i) begin
            if (armed_q) begin
              ended_d   = 1'b1;
              width_d   = edge_count_i;
              falling_d = 1'b0;
            end else begin
              ended_d   = 1'b0;
              ovf_cnt_d = '0;
              width_d   = '0;
              armed_d   = 1'b1;
              falling_d = 1'b1;
              restart   = 1'b1;
            end
          end
        end
      end
      OP_TICK: begin
        if (line_level_i) begin
          link_d = 1'b1;
          if ({1'b0, gap_low_q} < sup_cnt_q && sup_cnt_q < {1'b0, gap_high_q}) begin
            gap_d = 1'b1;
          end
          sup_cnt_d = '0;
        end else begin
          if (sup_cnt_q > {1'b0, lost_limit_q}) begin
            link_d    = 1'b0;
            width_d   = '0;
            link_base = '0;
          end
          sup_cnt_d = link_base + LinkCntW'(tick_step_q);
        end
        // classify from the width as it stands after the line update
        if (ended_q) begin
          if (press_low_q < width_d && width_d < band_split_q) begin
            key_d   = 1'b1;
            press_d = 1'b1;
            link_d  = 1'b1;
          end else if (band_split_q < width_d && width_d < release_high_q) begin
            key_d  = 1'b0;
            link_d = 1'b1;
          end
        end
      end
      OP_ACK: begin
        ended_d   = 1'b0;
        armed_d   = 1'b0;
        ovf_cnt_d = '0;
      end
      default: ;
    endcase

    res_d.falling_select = falling_d;
    res_d.restart_timer  = restart;
    res_d.capture_ended  = ended_d;
    res_d.pulse_width    = width_d;
    res_d.link_present   = link_d;
    res_d.gap_flag       = gap_d;
    res_d.key_pressed    = key_d;
    res_d.press_mark     = press_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ended_q   <= 1'b0;
      armed_q   <= 1'b0;
      ovf_cnt_q <= '0;
      width_q   <= '0;
      falling_q <= 1'b0;
      sup_cnt_q <= '0;
      link_q    <= 1'b0;
      gap_q     <= 1'b0;
      key_q     <= 1'b0;
      press_q   <= 1'b0;
    end else if (in_acc) begin
      ended_q   <= ended_d;
      armed_q   <= armed_d;
      ovf_cnt_q <= ovf_cnt_d;
      width_q   <= width_d;
      falling_q <= falling_d;
      sup_cnt_q <= sup_cnt_d;
      link_q    <= link_d;
      gap_q     <= gap_d;
      key_q     <= key_d;
      press_q   <= press_d;
    end
  end

  // output register and skid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (in_acc) begin
      if (out_valid_q && !out_take) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign falling_select_o = out_q.falling_select;
  assign restart_timer_o  = out_q.restart_timer;
  assign capture_ended_o  = out_q.capture_ended;
  assign pulse_width_o    = out_q.pulse_width;
  assign link_present_o   = out_q.link_present;
  assign gap_flag_o       = out_q.gap_flag;
  assign key_pressed_o    = out_q.key_pressed;
  assign press_mark_o     = out_q.press_mark;

endmodule

`default_nettype wire

### sim/tb_pulse_width_link_classifier.sv
// testbench for pulse_width_link_classifier: random and directed capture, tick and ack words
// checked against a cycle-free tracker of the capture and link state; needs pwlc_pkg
`timescale 1ns / 1ps

module tb_pulse_width_link_classifier;
  import pwlc_pkg::*;

  typedef struct {
    logic [OpW-1:0]    opcode;
    logic              ovf_ev;
    logic              edge_ev;
    logic [WidthW-1:0] edge_cnt;
    logic              line_lvl;
  } in_word_t;

  // tracks capture and link state, holds the results still to come
  class classifier_tracker;
    logic [StepW-1:0]    tick_step;
    logic [GapW-1:0]     lost_limit, gap_low, gap_high;
    logic [WidthW-1:0]   press_low, band_split, release_high;
    logic                ended, armed, falling, link_up, gap_seen, key_state, press_seen;
    int unsigned         ovf_cnt;
    logic [WidthW-1:0]   width;
    logic [LinkCntW-1:0] sup_cnt;
    res_t                result_words[$];
    int                  errors;

    function new();
      tick_step    = TickStepRst;
      lost_limit   = LostLimitRst;
      gap_low      = GapLowRst;
      gap_high     = GapHighRst;
      press_low    = PressLowRst;
      band_split   = BandSplitRst;
      release_high = ReleaseHighRst;
      ended        = 1'b0;
      armed        = 1'b0;
      falling      = 1'b0;
      link_up      = 1'b0;
      gap_seen     = 1'b0;
      key_state    = 1'b0;
      press_seen   = 1'b0;
      ovf_cnt      = 0;
      width        = '0;
      sup_cnt      = '0;
      errors       = 0;
    endfunction

    function void set_reg(cfg_e idx, logic [CfgDataW-1:0] v);
      case (idx)
        CFG_TICK_STEP:    tick_step    = v[StepW-1:0];
        CFG_LOST_LIMIT:   lost_limit   = v[GapW-1:0];
        CFG_GAP_LOW:      gap_low      = v[GapW-1:0];
        CFG_GAP_HIGH:     gap_high     = v[GapW-1:0];
        CFG_PRESS_LOW:    press_low    = v;
        CFG_BAND_SPLIT:   band_split   = v;
        CFG_RELEASE_HIGH: release_high = v;
        default: ;
      endcase
    endfunction

    function void apply_word(in_word_t w);
      res_t r;
      logic restart;
      restart = 1'b0;
      case (w.opcode)
        OP_CAPTURE: begin
          if (!ended) begin
            if (w.ovf_ev && armed) begin
              if (ovf_cnt >= OvfLimitDefault) begin
                ended = 1'b1;
                width = WidthSat;
              end else begin
                ovf_cnt++;
              end
            end
            // the edge still counts when the overflow just saturated
            if (w.edge_ev) begin
              if (armed) begin
                ended   = 1'b1;
                width   = w.edge_cnt;
                falling = 1'b0;
              end else begin
                ended   = 1'b0;
                ovf_cnt = 0;
                width   = '0;
                armed   = 1'b1;
                falling = 1'b1;
                restart = 1'b1;
              end
            end
          end
        end
        OP_TICK: begin
          if (w.line_lvl) begin
            link_up = 1'b1;
            if (gap_low < sup_cnt && sup_cnt < gap_high) gap_seen = 1'b1;
            sup_cnt = '0;
          end else begin
            if (sup_cnt > lost_limit) begin
              link_up = 1'b0;
              width   = '0;
              sup_cnt = '0;
            end
            sup_cnt = sup_cnt + LinkCntW'(tick_step);
          end
          if (ended) begin
            if (press_low < width && width < band_split) begin
              key_state  = 1'b1;
              press_seen = 1'b1;
              link_up    = 1'b1;
            end else if (band_split < width && width < release_high) begin
              key_state = 1'b0;
              link_up   = 1'b1;
            end
          end
        end
        OP_ACK: begin
          ended   = 1'b0;
          armed   = 1'b0;
          ovf_cnt = 0;
        end
        default: ;
      endcase
      r.falling_select = falling;
      r.restart_timer  = restart;
      r.capture_ended  = ended;
      r.pulse_width    = width;
      r.link_present   = link_up;
      r.gap_flag       = gap_seen;
      r.key_pressed    = key_state;
      r.press_mark     = press_seen;
      result_words.push_back(r);
    endfunction

    function void cmp(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
        $error("%s expected %0d got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_word(res_t got);
      res_t e;
      if (result_words.size() == 0) begin
        $error("result word with no prediction waiting");
        errors++;
        return;
      end
      e = result_words.pop_front();
      cmp("falling_select", e.falling_select, got.falling_select);
      cmp("restart_timer", e.restart_timer, got.restart_timer);
      cmp("capture_ended", e.capture_ended, got.capture_ended);
      cmp("pulse_width", e.pulse_width, got.pulse_width);
      cmp("link_present", e.link_present, got.link_present);
      cmp("gap_flag", e.gap_flag, got.gap_flag);
      cmp("key_pressed", e.key_pressed, got.key_pressed);
      cmp("press_mark", e.press_mark, got.press_mark);
    endfunction

    function int waiting();
      return result_words.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni           = 1'b0;
  logic                cfg_we           = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx          = '0;
  logic [CfgDataW-1:0] cfg_data         = '0;
  logic                in_valid         = 1'b0;
  logic [OpW-1:0]      opcode           = '0;
  logic                overflow_event   = 1'b0;
  logic                edge_event       = 1'b0;
  logic [WidthW-1:0]   edge_count       = '0;
  logic                line_level       = 1'b0;
  logic                out_stall        = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  res_t                dut_res;
  classifier_tracker   tracker          = new();
  in_word_t            stim_q[$];
  bit                  long_hold_req    = 1'b0;

  pulse_width_link_classifier i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode),
    .overflow_event_i (overflow_event),
    .edge_event_i     (edge_event),
    .edge_count_i     (edge_count),
    .line_level_i     (line_level),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .falling_select_o (dut_res.falling_select),
    .restart_timer_o  (dut_res.restart_timer),
    .capture_ended_o  (dut_res.capture_ended),
    .pulse_width_o    (dut_res.pulse_width),
    .link_present_o   (dut_res.link_present),
    .gap_flag_o       (dut_res.gap_flag),
    .key_pressed_o    (dut_res.key_pressed),
    .press_mark_o     (dut_res.press_mark)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) tracker.check_word(dut_res);
  end

  // receiver: stall modes that change now and then, plus a long hold-off on request
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    int phase_cnt;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    phase_cnt = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = 80;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      phase_cnt++;
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= (phase_cnt % 3 == 0);
        endcase
      end
    end
  end

  function automatic void push(logic [OpW-1:0] op, logic ovf, logic edg,
                               logic [WidthW-1:0] cnt, logic lvl);
    in_word_t w;
    w.opcode   = op;
    w.ovf_ev   = ovf;
    w.edge_ev  = edg;
    w.edge_cnt = cnt;
    w.line_lvl = lvl;
    stim_q.push_back(w);
  endfunction

  function automatic logic [WidthW-1:0] pick_width();
    logic [WidthW-1:0] base;
    case ($urandom_range(0, 6))
      0:       base = tracker.press_low;
      1:       base = tracker.band_split;
      2:       base = tracker.release_high;
      3:       base = '0;
      4:       base = '1;
      default: return WidthW'($urandom);
    endcase
    return base + WidthW'($urandom_range(0, 2)) - WidthW'(1);
  endfunction

  // rising edge, some overflows, falling edge, then ticks to classify
  function automatic void gen_pulse();
    int n_ovf;
    if ($urandom_range(0, 4) != 0)
      push(OP_ACK, 1'($urandom), 1'($urandom), WidthW'($urandom), 1'($urandom));
    push(OP_CAPTURE, 1'($urandom), 1'b1, WidthW'($urandom), 1'($urandom));
    n_ovf = ($urandom_range(0, 5) == 0) ? $urandom_range(62, 66) : $urandom_range(0, 3);
    for (int i = 0; i < n_ovf; i++)
      push(OP_CAPTURE, 1'b1, (i == n_ovf - 1) && ($urandom_range(0, 3) == 0),
           WidthW'($urandom), 1'($urandom));
    push(OP_CAPTURE, $urandom_range(0, 3) == 0, 1'b1, pick_width(), 1'($urandom));
    repeat ($urandom_range(1, 2))
      push(OP_TICK, 1'($urandom), 1'($urandom), WidthW'($urandom), 1'($urandom));
  endfunction

  // clear the link counter, run it up to near a bound or to a random count, then sample a high line
  function automatic void gen_link();
    int target;
    int n;
    push(OP_TICK, 1'($urandom), 1'($urandom), WidthW'($urandom), 1'b1);
    case ($urandom_range(0, 3))
      0:       target = int'(tracker.gap_low) + $urandom_range(0, 2) - 1;
      1:       target = int'(tracker.gap_high) + $urandom_range(0, 2) - 1;
      2:       target = int'(tracker.lost_limit) + $urandom_range(0, 2) - 1;
      default: target = $urandom_range(0, int'(tracker.lost_limit) + 300);
    endcase
    if (target < 0) target = 0;
    n = (target + int'(tracker.tick_step) - 1) / int'(tracker.tick_step);
    n = n + $urandom_range(0, 1);
    if (n > 150) n = 150;
    repeat (n) push(OP_TICK, 1'($urandom), 1'($urandom), WidthW'($urandom), 1'b0);
    push(OP_TICK, 1'($urandom), 1'($urandom), WidthW'($urandom), 1'b1);
  endfunction

  function automatic void gen_noise();
    repeat ($urandom_range(1, 5))
      push(OpW'($urandom_range(0, 3)), 1'($urandom), 1'($urandom), WidthW'($urandom),
           1'($urandom));
  endfunction

  task automatic drive_words();
    in_word_t w;
    int burst;
    int gap;
    while (stim_q.size() != 0) begin
      burst = $urandom_range(1, 32);
      while (burst != 0 && stim_q.size() != 0) begin
        w = stim_q.pop_front();
        @(negedge clk_i);
        in_valid       <= 1'b1;
        opcode         <= w.opcode;
        overflow_event <= w.ovf_ev;
        edge_event     <= w.edge_ev;
        edge_count     <= w.edge_cnt;
        line_level     <= w.line_lvl;
        @(posedge clk_i);
        while (in_stall_o) @(posedge clk_i);
        tracker.apply_word(w);
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0 || stim_q.size() == 0) begin
        @(negedge clk_i);
        in_valid   <= 1'b0;
        edge_count <= WidthW'($urandom);
        // sometimes let the block run dry before the next burst
        if ($urandom_range(0, 19) == 0)
          while (tracker.waiting() != 0) @(posedge clk_i);
        if (gap > 1) repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    while (tracker.waiting() != 0 && n < 5000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_e idx, int unsigned v);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CfgDataW'(v);
    tracker.set_reg(idx, CfgDataW'(v));
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(int unsigned step, int unsigned lost, int unsigned glo,
                                int unsigned ghi, int unsigned plo, int unsigned split,
                                int unsigned rhi);
    write_reg(CFG_TICK_STEP, step);
    write_reg(CFG_LOST_LIMIT, lost);
    write_reg(CFG_GAP_LOW, glo);
    write_reg(CFG_GAP_HIGH, ghi);
    write_reg(CFG_PRESS_LOW, plo);
    write_reg(CFG_BAND_SPLIT, split);
    write_reg(CFG_RELEASE_HIGH, rhi);
  endtask

  task automatic run_random(int budget);
    int r;
    while (stim_q.size() < budget) begin
      r = $urandom_range(0, 9);
      if (r < 5) gen_pulse();
      else if (r < 8) gen_link();
      else gen_noise();
    end
    // keep each phase at its word count
    while (stim_q.size() > budget) void'(stim_q.pop_back());
    long_hold_req = 1'b1;
    drive_words();
    wait_drained();
  endtask

  initial begin
    int unsigned glo;
    int unsigned plo;
    int unsigned split;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // directed pass at reset settings
    push(2'd3, 1'b1, 1'b1, '1, 1'b1);
    push(OP_TICK, 1'b0, 1'b0, '0, 1'b1);
    push(OP_CAPTURE, 1'b1, 1'b0, '0, 1'b0);       // overflow while not armed
    push(OP_CAPTURE, 1'b0, 1'b1, '0, 1'b0);
    push(OP_CAPTURE, 1'b1, 1'b0, '0, 1'b0);
    push(OP_CAPTURE, 1'b0, 1'b1, 16'd200, 1'b0);
    push(OP_CAPTURE, 1'b1, 1'b1, 16'd5, 1'b0);    // ignored once ended
    push(OP_TICK, 1'b0, 1'b0, '0, 1'b0);
    push(OP_ACK, 1'b0, 1'b0, '0, 1'b0);
    push(OP_CAPTURE, 1'b1, 1'b1, '0, 1'b0);
    push(OP_CAPTURE, 1'b1, 1'b1, 16'd300, 1'b0);
    push(OP_TICK, 1'b0, 1'b0, '0, 1'b1);
    push(OP_ACK, 1'b0, 1'b0, '0, 1'b0);
    push(OP_CAPTURE, 1'b0, 1'b1, '0, 1'b0);
    push(OP_CAPTURE, 1'b0, 1'b1, 16'd250, 1'b0);  // on the split, no class
    push(OP_TICK, 1'b0, 1'b0, '0, 1'b1);
    push(OP_ACK, 1'b0, 1'b0, '0, 1'b0);
    push(OP_CAPTURE, 1'b0, 1'b1, '0, 1'b0);
    push(OP_CAPTURE, 1'b0, 1'b1, 16'd150, 1'b0);
    push(OP_TICK, 1'b0, 1'b0, '0, 1'b0);
    push(OP_ACK, 1'b0, 1'b0, '0, 1'b0);
    push(OP_CAPTURE, 1'b0, 1'b1, '0, 1'b0);
    push(OP_CAPTURE, 1'b0, 1'b1, '1, 1'b0);
    push(OP_TICK, 1'b0, 1'b0, '0, 1'b0);
    push(OP_ACK, 1'b1, 1'b1, '1, 1'b1);
    drive_words();
    wait_drained();

    apply_settings(10, 1000, 100, 500, 150, 250, 350);
    run_random(185);
    apply_settings(255, 0, 0, 2047, 0, 32768, 65535);
    run_random(185);
    apply_settings(1, 2047, 2047, 0, 65535, 0, 0);
    run_random(185);
    repeat (2) begin
      glo   = $urandom_range(0, 600);
      plo   = $urandom_range(0, 2000);
      split = plo + $urandom_range(0, 1000);
      apply_settings($urandom_range(1, 255), $urandom_range(0, 2047), glo,
                     glo + $urandom_range(0, 600), plo, split,
                     split + $urandom_range(0, 1000));
      run_random(185);
    end

    if (tracker.errors == 0 && tracker.waiting() == 0) begin
      $display("== PASS ==");
    end else begin
      if (tracker.waiting() != 0) $error("%0d predicted results never came", tracker.waiting());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
src/pwlc_pkg.sv
src/pulse_width_link_classifier.sv
sim/tb_pulse_width_link_classifier.sv
